@@ src/atl_pkg.sv @@
package atl_pkg;

   // Width of the line, column and text offset counters and of the position fields.
   localparam int POS_W = 24;

   // Depth of the result bundle queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Most results a single input byte can cause.
   localparam int MAX_RESULTS = 3;

   // Result kinds.
   localparam logic [1:0] KIND_TOKEN = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_EOT   = 2'd3;

   // Token types beyond the punctuation codes.
   localparam logic [3:0] TOK_NONE    = 4'd0;
   localparam logic [3:0] TOK_NEWLINE = 4'd13;
   localparam logic [3:0] TOK_WORD    = 4'd14;
   localparam logic [3:0] TOK_NUMBER  = 4'd15;

   // Error codes.
   localparam logic ERR_COMMENT    = 1'b0;
   localparam logic ERR_UNEXPECTED = 1'b1;

   // Characters with a role of their own.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_X     = 8'h78;

   // Punctuation characters, in token code order: $ # @ ( ) * - + % [ ] = :
   localparam int PUNCT_N = 13;
   localparam logic [7:0] PUNCT_CHARS [PUNCT_N] = '{
      8'h24, 8'h23, 8'h40, 8'h28, 8'h29, 8'h2A, 8'h2D,
      8'h2B, 8'h25, 8'h5B, 8'h5D, 8'h3D, 8'h3A
   };

   typedef enum logic [7:0] {
      MODE_NORMAL  = 8'b0000_0001,
      MODE_NUMBER  = 8'b0000_0010,
      MODE_HEX     = 8'b0000_0100,
      MODE_WORD    = 8'b0000_1000,
      MODE_COMMENT = 8'b0001_0000,
      MODE_SLASH   = 8'b0010_0000,
      MODE_DIGIT   = 8'b0100_0000,
      MODE_ERROR   = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       ttype;
      logic [POS_W-1:0] line;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] off;
      logic [7:0]       bval;
      logic             code;
   } rec_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [1:0]                cnt;
      rec_type [MAX_RESULTS-1:0] recs;
   } bundle_type;

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] x);
      return (&x) ? x : x + POS_W'(1);
   endfunction

   function automatic rec_type mk_rec(input logic [1:0] kind, input logic [3:0] ttype,
                                      input logic [POS_W-1:0] line,
                                      input logic [POS_W-1:0] col,
                                      input logic [POS_W-1:0] off,
                                      input logic [7:0] bval, input logic code);
      rec_type r;
      r.kind  = kind;
      r.ttype = ttype;
      r.line  = line;
      r.col   = col;
      r.off   = off;
      r.bval  = bval;
      r.code  = code;
      return r;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   // Returns {hit, code}; the characters are distinct so at most one matches.
   function automatic logic [4:0] punct_lookup(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      for (int i = 0; i < PUNCT_N; i++) begin
         if (c == PUNCT_CHARS[i]) begin
            r = {1'b1, 4'(i)};
         end
      end
      return r;
   endfunction

endpackage

@@ src/atl_if.sv @@
interface atl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface atl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                result_kind;
   logic [3:0]                token_type;
   logic [atl_pkg::POS_W-1:0] line_number;
   logic [atl_pkg::POS_W-1:0] column;
   logic [atl_pkg::POS_W-1:0] string_offset;
   logic [7:0]                byte_value;
   logic                      error_code;
   logic                      last_result;
   modport source (output valid, output result_kind, output token_type, output line_number,
                   output column, output string_offset, output byte_value,
                   output error_code, output last_result, input ready);
   modport sink (input valid, input result_kind, input token_type, input line_number,
                 input column, input string_offset, input byte_value,
                 input error_code, input last_result, output ready);
endinterface

@@ src/atl_front.sv @@
module atl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_ch,
   output logic                 push_valid,
   input  logic                 push_ready,
   output atl_pkg::bundle_type  push_data
);

   atl_pkg::mode_type mode_ff, mode_in;
   logic [atl_pkg::POS_W-1:0] line_ff, line_in;
   logic [atl_pkg::POS_W-1:0] col_ff, col_in;
   logic [atl_pkg::POS_W-1:0] off_ff, off_in;
   logic [atl_pkg::POS_W-1:0] slash_ff, slash_in;
   logic have_ff, have_in;
   logic lastnl_ff, lastnl_in;
   logic held_ff, held_in;

   logic                      accept;
   logic                      cont, fin, handle, nl_seen;
   logic [atl_pkg::POS_W-1:0] o;
   logic [4:0]                pl;
   atl_pkg::rec_type          h0, h1;
   logic [1:0]                hn;
   atl_pkg::bundle_type       b;

   assign in_ready   = push_ready;
   assign accept     = in_valid & in_ready;
   assign push_valid = accept & (b.cnt != 2'd0);
   assign push_data  = b;
   assign pl         = atl_pkg::punct_lookup(in_ch);

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      off_in    = off_ff;
      slash_in  = slash_ff;
      have_in   = have_ff;
      lastnl_in = lastnl_ff;
      held_in   = held_ff;
      b         = '0;
      cont      = 1'b0;
      fin       = 1'b0;
      handle    = 1'b0;
      nl_seen   = 1'b0;
      h0        = '0;
      h1        = '0;
      hn        = 2'd0;

      unique case (mode_ff)
         atl_pkg::MODE_NORMAL:  handle = 1'b1;
         atl_pkg::MODE_NUMBER:  cont = atl_pkg::is_digit(in_ch);
         atl_pkg::MODE_HEX:     cont = atl_pkg::is_hex(in_ch);
         atl_pkg::MODE_WORD:    cont = atl_pkg::is_letter(in_ch) | atl_pkg::is_digit(in_ch);
         atl_pkg::MODE_DIGIT:   cont = atl_pkg::is_digit(in_ch) | (in_ch == atl_pkg::CH_X);
         atl_pkg::MODE_COMMENT: handle = (in_ch == atl_pkg::CH_NL);
         atl_pkg::MODE_SLASH:   ;
         atl_pkg::MODE_ERROR:   ;
         default:               ;
      endcase
      if ((mode_ff == atl_pkg::MODE_NUMBER) || (mode_ff == atl_pkg::MODE_HEX) ||
          (mode_ff == atl_pkg::MODE_WORD) || (mode_ff == atl_pkg::MODE_DIGIT)) begin
         fin    = ~cont;
         handle = ~cont;
      end

      // A finished word or number first takes one offset for its zero byte.
      o = fin ? atl_pkg::sat_inc(off_ff) : off_ff;

      if (in_ch == atl_pkg::CH_NUL) begin
         if (mode_ff == atl_pkg::MODE_SLASH) begin
            b.recs[0] = atl_pkg::mk_rec(atl_pkg::KIND_ERROR, atl_pkg::TOK_NONE, line_ff,
                                        slash_ff, '0, 8'h00, atl_pkg::ERR_COMMENT);
            b.recs[1] = atl_pkg::mk_rec(atl_pkg::KIND_EOT, atl_pkg::TOK_NONE, line_ff,
                                        col_ff, off_ff, 8'h00, 1'b0);
            b.cnt     = 2'd2;
         end else begin
            b.recs[0] = atl_pkg::mk_rec(atl_pkg::KIND_EOT, atl_pkg::TOK_NONE, line_ff,
                                        col_ff, off_ff, 8'h00, 1'b0);
            b.cnt     = 2'd1;
         end
         mode_in   = atl_pkg::MODE_NORMAL;
         line_in   = atl_pkg::POS_W'(1);
         col_in    = atl_pkg::POS_W'(1);
         off_in    = '0;
         slash_in  = '0;
         have_in   = 1'b0;
         lastnl_in = 1'b0;
         held_in   = 1'b0;
      end else begin
         if (cont) begin
            b.recs[0] = atl_pkg::mk_rec(atl_pkg::KIND_BYTE, atl_pkg::TOK_NONE, line_ff,
                                        col_ff, off_ff, in_ch, 1'b0);
            b.cnt     = 2'd1;
            off_in    = atl_pkg::sat_inc(off_ff);
            if (mode_ff == atl_pkg::MODE_DIGIT) begin
               mode_in = (in_ch == atl_pkg::CH_X) ? atl_pkg::MODE_HEX : atl_pkg::MODE_NUMBER;
            end
         end else if (handle) begin
            mode_in = atl_pkg::MODE_NORMAL;
            off_in  = o;
            priority if (pl[4]) begin
               h0        = atl_pkg::mk_rec(atl_pkg::KIND_TOKEN, pl[3:0], line_ff, col_ff,
                                           '0, 8'h00, 1'b0);
               hn        = 2'd1;
               have_in   = 1'b1;
               lastnl_in = 1'b0;
            end else if (in_ch == atl_pkg::CH_NL) begin
               nl_seen = 1'b1;
               if (have_ff && !lastnl_ff) begin
                  h0        = atl_pkg::mk_rec(atl_pkg::KIND_TOKEN, atl_pkg::TOK_NEWLINE,
                                              line_ff, col_ff, '0, 8'h00, 1'b0);
                  hn        = 2'd1;
                  lastnl_in = 1'b1;
               end
            end else if (in_ch == atl_pkg::CH_SLASH) begin
               slash_in = col_ff;
               mode_in  = atl_pkg::MODE_SLASH;
            end else if (atl_pkg::is_letter(in_ch) || atl_pkg::is_digit(in_ch)) begin
               h0        = atl_pkg::mk_rec(atl_pkg::KIND_TOKEN,
                                           atl_pkg::is_letter(in_ch) ? atl_pkg::TOK_WORD
                                                                     : atl_pkg::TOK_NUMBER,
                                           line_ff, col_ff, o, 8'h00, 1'b0);
               h1        = atl_pkg::mk_rec(atl_pkg::KIND_BYTE, atl_pkg::TOK_NONE, line_ff,
                                           col_ff, o, in_ch, 1'b0);
               hn        = 2'd2;
               off_in    = atl_pkg::sat_inc(o);
               have_in   = 1'b1;
               lastnl_in = 1'b0;
               mode_in   = atl_pkg::is_letter(in_ch) ? atl_pkg::MODE_WORD
                                                     : atl_pkg::MODE_DIGIT;
            end else if ((in_ch == atl_pkg::CH_SPACE) || (in_ch == atl_pkg::CH_COMMA) ||
                         (in_ch == atl_pkg::CH_TAB)) begin
               // Whitespace gives nothing.
            end else begin
               h0       = atl_pkg::mk_rec(atl_pkg::KIND_ERROR, atl_pkg::TOK_NONE, line_ff,
                                          col_ff, '0, 8'h00, atl_pkg::ERR_UNEXPECTED);
               hn       = 2'd1;
               slash_in = col_ff;
               held_in  = atl_pkg::ERR_UNEXPECTED;
               mode_in  = atl_pkg::MODE_ERROR;
            end
            if (fin) begin
               b.recs[0] = atl_pkg::mk_rec(atl_pkg::KIND_BYTE, atl_pkg::TOK_NONE, line_ff,
                                           col_ff, off_ff, 8'h00, 1'b0);
               b.recs[1] = h0;
               b.recs[2] = h1;
               b.cnt     = hn + 2'd1;
            end else begin
               b.recs[0] = h0;
               b.recs[1] = h1;
               b.cnt     = hn;
            end
         end else if (mode_ff == atl_pkg::MODE_SLASH) begin
            if (in_ch == atl_pkg::CH_SLASH) begin
               mode_in = atl_pkg::MODE_COMMENT;
            end else begin
               b.recs[0] = atl_pkg::mk_rec(atl_pkg::KIND_ERROR, atl_pkg::TOK_NONE, line_ff,
                                           slash_ff, '0, 8'h00, atl_pkg::ERR_COMMENT);
               b.cnt     = 2'd1;
               held_in   = atl_pkg::ERR_COMMENT;
               mode_in   = atl_pkg::MODE_ERROR;
            end
         end else if (mode_ff == atl_pkg::MODE_ERROR) begin
            b.recs[0] = atl_pkg::mk_rec(atl_pkg::KIND_ERROR, atl_pkg::TOK_NONE, line_ff,
                                        slash_ff, '0, 8'h00, held_ff);
            b.cnt     = 2'd1;
         end

         // Position advances unless the lexer has gone into its error state.
         if (mode_in != atl_pkg::MODE_ERROR) begin
            if (nl_seen) begin
               line_in = atl_pkg::sat_inc(line_ff);
               col_in  = atl_pkg::POS_W'(1);
            end else begin
               col_in  = atl_pkg::sat_inc(col_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= atl_pkg::MODE_NORMAL;
         line_ff   <= atl_pkg::POS_W'(1);
         col_ff    <= atl_pkg::POS_W'(1);
         off_ff    <= '0;
         slash_ff  <= '0;
         have_ff   <= 1'b0;
         lastnl_ff <= 1'b0;
         held_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         off_ff    <= off_in;
         slash_ff  <= slash_in;
         have_ff   <= have_in;
         lastnl_ff <= lastnl_in;
         held_ff   <= held_in;
      end
   end

endmodule

@@ src/atl_queue.sv @@
module atl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  atl_pkg::bundle_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output atl_pkg::bundle_type pop_data
);

   atl_pkg::bundle_type entry_ff [atl_pkg::QUEUE_DEPTH];
   logic [atl_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [atl_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [atl_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                       do_push, do_pop;

   assign push_ready = (cnt_ff != atl_pkg::QCNT_W'(atl_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == atl_pkg::QPTR_W'(atl_pkg::QUEUE_DEPTH - 1))
                 ? '0 : wr_ff + atl_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == atl_pkg::QPTR_W'(atl_pkg::QUEUE_DEPTH - 1))
                 ? '0 : rd_ff + atl_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + atl_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - atl_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ src/atl_back.sv @@
module atl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   output logic                head_pop,
   input  atl_pkg::bundle_type head,
   atl_rsp_if.source           rsp
);

   logic [1:0]       idx_ff, idx_in;
   logic             last, fire;
   atl_pkg::rec_type r;

   assign r    = head.recs[idx_ff];
   assign last = (idx_ff == head.cnt - 2'd1);
   assign fire = rsp.valid & rsp.ready;

   assign rsp.valid         = head_valid;
   assign rsp.result_kind   = r.kind;
   assign rsp.token_type    = r.ttype;
   assign rsp.line_number   = r.line;
   assign rsp.column        = r.col;
   assign rsp.string_offset = r.off;
   assign rsp.byte_value    = r.bval;
   assign rsp.error_code    = r.code;
   assign rsp.last_result   = last;
   assign head_pop          = fire & last;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

@@ src/assembler_token_lexer.sv @@
// Channel   Direction  Handshake         Item contents
// req       in         valid/ready       ch: one source byte, zero ends the text
// rsp       out        valid/ready       one result: kind, token type, line, column,
//                                        text offset, byte, error code, last flag
//
// A byte is accepted in every cycle while the result queue has room, and one
// result leaves per cycle while the receiver is ready, so the input runs at one
// byte per cycle whenever each byte gives at most one result; a byte that gives
// two or three results holds the output until all have left, and the two-entry
// queue absorbs it. A byte is classified and the lexer state updated in the
// cycle it is accepted, and its results are then held in the queue.
// Reset is synchronous and returns the lexer to line one, column one, with
// an empty queue. Input and output stall independently through the queue.
module assembler_token_lexer (
   input  logic     clock,
   input  logic     reset,
   atl_req_if.sink  req,
   atl_rsp_if.source rsp
);

   // Bundles of all results caused by one byte pass from the front part,
   // which owns the lexer state, to the back part, which hands them out one
   // at a time and marks the last of each bundle.
   logic                push_valid, push_ready;
   atl_pkg::bundle_type push_data;
   logic                head_valid, head_pop;
   atl_pkg::bundle_type head;

   atl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .in_ch      (req.ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Bytes that cause no result (whitespace, comment text, a first slash)
   // never enter the queue.
   atl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_data   (head)
   );

   atl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head       (head),
      .rsp        (rsp)
   );

endmodule

@@ tb/sv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import atl_pkg::*;

   // Source bytes sent in all, directed and random together.
   localparam int TOTAL_ITEMS = 250;
   // Bytes sent before the receiver holds off once.
   localparam int SQUEEZE_AT = 120;
   // The receiver holds off this long once, so that the result queue backs up into the input.
   localparam int HOLD_OFF = 60;
   // Quiet cycles after the last expected result, to catch any stray result.
   localparam int DRAIN_CYCLES = 40;
   // Cycles without any handshake before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 2000;

   // One expected result: the record plus the flag that marks the last result of a byte.
   typedef struct packed {
      rec_type rec;
      logic    last;
   } result_type;

   // One row of the directed text. Rows with typed set carry their single result in
   // want; the others are checked against the lexer model below.
   typedef struct packed {
      logic [7:0] ch;
      logic       typed;
      rec_type    want;
   } step_row_type;

   localparam rec_type NO_REC = '0;

   localparam int DIRECTED_N = 27;
   localparam step_row_type DIRECTED [DIRECTED_N] = '{
      // Punctuation right after reset: first token at line 1, column 1.
      {"$", 1'b1, KIND_TOKEN, 4'd0, 24'd1, 24'd1, 24'd0, 8'd0, 1'b0},
      {":", 1'b1, KIND_TOKEN, 4'd12, 24'd1, 24'd2, 24'd0, 8'd0, 1'b0},
      // A newline after a token gives a newline token; a second one gives nothing.
      {CH_NL, 1'b1, KIND_TOKEN, TOK_NEWLINE, 24'd1, 24'd3, 24'd0, 8'd0, 1'b0},
      {CH_NL, 1'b0, NO_REC},
      // A word closed by a space.
      {"A", 1'b0, NO_REC},
      {"z", 1'b0, NO_REC},
      {"9", 1'b0, NO_REC},
      {CH_SPACE, 1'b0, NO_REC},
      // A hex number closed by a letter, which starts a word in the same byte.
      {"0", 1'b0, NO_REC},
      {CH_X, 1'b0, NO_REC},
      {"F", 1'b0, NO_REC},
      {"g", 1'b0, NO_REC},
      {CH_COMMA, 1'b0, NO_REC},
      // A decimal number closed by a slash that opens a comment.
      {"9", 1'b0, NO_REC},
      {"9", 1'b0, NO_REC},
      {CH_SLASH, 1'b0, NO_REC},
      {CH_SLASH, 1'b0, NO_REC},
      {8'hFF, 1'b0, NO_REC},
      {CH_NL, 1'b0, NO_REC},
      // A lone slash, the sticky error that follows, and end of text.
      {CH_SLASH, 1'b0, NO_REC},
      {"a", 1'b0, NO_REC},
      {8'h80, 1'b0, NO_REC},
      {CH_NUL, 1'b0, NO_REC},
      // Unknown byte right after end of text, then end of text with frozen counters.
      {8'hFF, 1'b1, KIND_ERROR, TOK_NONE, 24'd1, 24'd1, 24'd0, 8'd0, ERR_UNEXPECTED},
      {CH_NUL, 1'b1, KIND_EOT, TOK_NONE, 24'd1, 24'd1, 24'd0, 8'd0, 1'b0},
      // A slash still pending when the text ends gives an error and then end of text.
      {CH_SLASH, 1'b0, NO_REC},
      {CH_NUL, 1'b0, NO_REC}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   atl_req_if req ();
   atl_rsp_if rsp ();

   assembler_token_lexer i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   always #10 clock = ~clock;

   // Lexer model state.
   mode_type    lex_state;
   logic [23:0] cur_line;
   logic [23:0] cur_col;
   logic [23:0] cur_off;
   logic [23:0] err_col;
   logic        err_code;
   logic        seen_token;
   logic        prev_newline;
   logic        line_ended;
   result_type  byte_results[$];

   // Results still owed by the block, oldest first.
   result_type  pending_results[$];
   // Source text waiting to be sent during the random part.
   logic [7:0]  script[$];

   int          mismatches = 0;
   int          bytes_sent = 0;
   int          busy_items = 0;
   int          quiet_cycles = 0;
   int          tokens_seen = 0;
   int          text_bytes_seen = 0;
   int          errors_seen = 0;
   int          ends_seen = 0;
   logic        steady = 1'b0;
   logic        squeeze_now = 1'b0;
   logic        squeezed = 1'b0;

   // ------------------------------------------------------------------
   // Lexer model
   // ------------------------------------------------------------------

   function automatic logic [23:0] bump(input logic [23:0] v);
      return (v == '1) ? v : v + 24'd1;
   endfunction

   function automatic logic dec_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic hex_digit(input logic [7:0] c);
      return dec_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic void add_result(input logic [1:0] kind, input logic [3:0] ttype,
                                      input logic [23:0] ln, input logic [23:0] col,
                                      input logic [23:0] off, input logic [7:0] bval,
                                      input logic code);
      result_type r;
      if (byte_results.size() >= MAX_RESULTS) return;
      r.rec.kind  = kind;
      r.rec.ttype = ttype;
      r.rec.line  = ln;
      r.rec.col   = col;
      r.rec.off   = off;
      r.rec.bval  = bval;
      r.rec.code  = code;
      r.last      = 1'b0;
      byte_results.push_back(r);
   endfunction

   function automatic void text_byte(input logic [7:0] b);
      add_result(KIND_BYTE, TOK_NONE, cur_line, cur_col, cur_off, b, 1'b0);
      cur_off = bump(cur_off);
   endfunction

   function automatic void token(input logic [3:0] ttype, input logic [23:0] off);
      add_result(KIND_TOKEN, ttype, cur_line, cur_col, off, 8'd0, 1'b0);
      seen_token = 1'b1;
      prev_newline = (ttype == TOK_NEWLINE);
   endfunction

   function automatic void flag_error(input logic [23:0] col, input logic code);
      add_result(KIND_ERROR, TOK_NONE, cur_line, col, 24'd0, 8'd0, code);
      err_col = col;
      err_code = code;
      lex_state = MODE_ERROR;
   endfunction

   function automatic void lexer_clear();
      lex_state = MODE_NORMAL;
      cur_line = 24'd1;
      cur_col = 24'd1;
      cur_off = 24'd0;
      err_col = 24'd0;
      err_code = ERR_COMMENT;
      seen_token = 1'b0;
      prev_newline = 1'b0;
   endfunction

   // A byte seen outside any word, number or comment.
   function automatic void lex_plain(input logic [7:0] c);
      int p;
      p = -1;
      for (int i = 0; i < PUNCT_N; i++) begin
         if (c == PUNCT_CHARS[i]) p = i;
      end
      if (p >= 0) begin
         token(4'(p), 24'd0);
      end else if (c == CH_NL) begin
         if (seen_token && !prev_newline) token(TOK_NEWLINE, 24'd0);
         line_ended = 1'b1;
      end else if (c == CH_SLASH) begin
         err_col = cur_col;
         lex_state = MODE_SLASH;
      end else if (alpha(c)) begin
         token(TOK_WORD, cur_off);
         text_byte(c);
         lex_state = MODE_WORD;
      end else if (dec_digit(c)) begin
         token(TOK_NUMBER, cur_off);
         text_byte(c);
         lex_state = MODE_DIGIT;
      end else if (c != CH_SPACE && c != CH_COMMA && c != CH_TAB) begin
         flag_error(cur_col, ERR_UNEXPECTED);
      end
   endfunction

   // Ends the open word or number and handles the byte that ended it.
   function automatic void close_text(input logic [7:0] c);
      text_byte(CH_NUL);
      lex_state = MODE_NORMAL;
      lex_plain(c);
   endfunction

   // Works out every result of one source byte into byte_results.
   function automatic void lex_byte(input logic [7:0] c);
      result_type r;
      byte_results.delete();
      line_ended = 1'b0;
      if (c == CH_NUL) begin
         if (lex_state == MODE_SLASH) begin
            add_result(KIND_ERROR, TOK_NONE, cur_line, err_col, 24'd0, 8'd0, ERR_COMMENT);
         end
         add_result(KIND_EOT, TOK_NONE, cur_line, cur_col, cur_off, 8'd0, 1'b0);
         lexer_clear();
      end else begin
         case (lex_state)
            MODE_NORMAL: lex_plain(c);
            MODE_NUMBER: if (dec_digit(c)) text_byte(c); else close_text(c);
            MODE_HEX: if (hex_digit(c)) text_byte(c); else close_text(c);
            MODE_WORD: if (alpha(c) || dec_digit(c)) text_byte(c); else close_text(c);
            MODE_COMMENT: begin
               if (c == CH_NL) begin
                  lex_state = MODE_NORMAL;
                  lex_plain(c);
               end
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) lex_state = MODE_COMMENT;
               else flag_error(err_col, ERR_COMMENT);
            end
            MODE_DIGIT: begin
               if (c == CH_X) begin
                  text_byte(c);
                  lex_state = MODE_HEX;
               end else if (dec_digit(c)) begin
                  text_byte(c);
                  lex_state = MODE_NUMBER;
               end else begin
                  close_text(c);
               end
            end
            default: add_result(KIND_ERROR, TOK_NONE, cur_line, err_col, 24'd0, 8'd0, err_code);
         endcase
         // Position counters stay frozen once an error is held.
         if (lex_state != MODE_ERROR) begin
            if (line_ended) begin
               cur_line = bump(cur_line);
               cur_col = 24'd1;
            end else begin
               cur_col = bump(cur_col);
            end
         end
      end
      if (byte_results.size() != 0) begin
         r = byte_results.pop_back();
         r.last = 1'b1;
         byte_results.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------
   // Random source text
   // ------------------------------------------------------------------

   // Most gaps are short, a few are long, and in steady stretches there are none.
   function automatic int unsigned idle_len();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_letter();
      int unsigned r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
   endfunction

   function automatic logic [7:0] pick_alnum();
      return ($urandom_range(0, 5) == 0) ? pick_digit() : pick_letter();
   endfunction

   function automatic logic [7:0] pick_hex();
      int unsigned r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'("0" + r);
      if (r < 16) return 8'("a" + r - 10);
      return 8'("A" + r - 16);
   endfunction

   // Appends one fragment of mostly well-formed assembler text, with some noise mixed in.
   function automatic void add_fragment();
      int unsigned kind;
      int unsigned n;
      logic [7:0]  b;
      if ($urandom_range(0, 19) == 0) steady = !steady;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
         script.push_back(pick_letter());
         n = $urandom_range(0, 5);
         repeat (n) script.push_back(pick_alnum());
      end else if (kind < 40) begin
         script.push_back(pick_digit());
         if ($urandom_range(0, 1) == 1) begin
            script.push_back(CH_X);
            n = $urandom_range(1, 4);
            repeat (n) script.push_back(pick_hex());
         end else begin
            n = $urandom_range(0, 3);
            repeat (n) script.push_back(pick_digit());
         end
      end else if (kind < 60) begin
         script.push_back(PUNCT_CHARS[$urandom_range(0, PUNCT_N - 1)]);
      end else if (kind < 72) begin
         n = $urandom_range(0, 2);
         script.push_back(n == 0 ? CH_SPACE : (n == 1 ? CH_TAB : CH_COMMA));
      end else if (kind < 80) begin
         script.push_back(CH_NL);
      end else if (kind < 86) begin
         // Comment with arbitrary content up to the newline.
         script.push_back(CH_SLASH);
         script.push_back(CH_SLASH);
         n = $urandom_range(0, 6);
         repeat (n) begin
            b = 8'($urandom_range(1, 255));
            script.push_back(b == CH_NL ? CH_SPACE : b);
         end
         script.push_back(CH_NL);
      end else if (kind < 90) begin
         // Malformed comment start, a few sticky error bytes, then end of text.
         script.push_back(CH_SLASH);
         if ($urandom_range(0, 3) != 0) begin
            b = 8'($urandom_range(1, 255));
            script.push_back(b == CH_SLASH ? CH_SPACE : b);
            n = $urandom_range(0, 3);
            repeat (n) script.push_back(8'($urandom_range(1, 255)));
         end
         script.push_back(CH_NUL);
      end else if (kind < 96) begin
         script.push_back(8'($urandom_range(1, 255)));
         if ($urandom_range(0, 1) == 1) script.push_back(CH_NUL);
      end else begin
         script.push_back(CH_NUL);
      end
   endfunction

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------

   // Offers one byte and waits for it to be taken. Valid stays high into the next
   // byte unless a gap is chosen, and no gap is taken while the receiver is held off.
   // For a typed row the typed record replaces the model's result.
   task automatic send_byte(input logic [7:0] c, input logic typed, input rec_type want);
      int unsigned gap;
      result_type  r;
      gap = squeeze_now ? 0 : idle_len();
      if (gap != 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid = 1'b1;
      req.ch = c;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      bytes_sent++;
      lex_byte(c);
      if (byte_results.size() != 0) busy_items++;
      if (typed) begin
         r.rec = want;
         r.last = 1'b1;
         pending_results.push_back(r);
      end else begin
         foreach (byte_results[k]) pending_results.push_back(byte_results[k]);
      end
      @(negedge clock);
   endtask

   initial begin
      int i;
      req.valid = 1'b0;
      req.ch = CH_NUL;
      lexer_clear();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed text: every special case once, with a few results typed in.
      for (i = 0; i < DIRECTED_N; i++) begin
         send_byte(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].want);
      end

      // Random text up to the total byte count. Partway through, the receiver
      // holds off for a long stretch while the sender keeps offering.
      while (bytes_sent < TOTAL_ITEMS) begin
         if (script.size() == 0) add_fragment();
         send_byte(script.pop_front(), 1'b0, NO_REC);
         if (bytes_sent >= SQUEEZE_AT && !squeezed) begin
            squeezed = 1'b1;
            squeeze_now = 1'b1;
         end
      end
      req.valid = 1'b0;

      // Let every owed result arrive, then watch a while longer for strays.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d source bytes (%0d directed, %0d with results) covering words,",
               bytes_sent, DIRECTED_N, busy_items);
      $display("numbers, comments, errors and end of text; results: %0d tokens, %0d text bytes, %0d errors, %0d ends.",
               tokens_seen, text_bytes_seen, errors_seen, ends_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver
   // ------------------------------------------------------------------

   // Ready changes at the falling edge: random stalls between bursts of ready, and the
   // single long hold-off when the sender asks for it.
   initial begin
      int unsigned n;
      rsp.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (squeeze_now) begin
            rsp.ready = 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
            squeeze_now = 1'b0;
         end else begin
            n = idle_len();
            if (n != 0) begin
               rsp.ready = 1'b0;
               repeat (n) @(negedge clock);
            end
            rsp.ready = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result check
   // ------------------------------------------------------------------

   function automatic void same(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 20) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         end
      end
   endfunction

   // Each result taken is compared field by field with the oldest one owed.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         case (rsp.result_kind)
            KIND_TOKEN: tokens_seen++;
            KIND_BYTE:  text_bytes_seen++;
            KIND_ERROR: errors_seen++;
            default:    ends_seen++;
         endcase
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected, kind %0d type %0d line %0d col %0d",
                     $time, rsp.result_kind, rsp.token_type, rsp.line_number, rsp.column);
         end else begin
            want = pending_results.pop_front();
            same("result_kind", 32'(want.rec.kind), 32'(rsp.result_kind));
            same("token_type", 32'(want.rec.ttype), 32'(rsp.token_type));
            same("line_number", 32'(want.rec.line), 32'(rsp.line_number));
            same("column", 32'(want.rec.col), 32'(rsp.column));
            same("string_offset", 32'(want.rec.off), 32'(rsp.string_offset));
            same("byte_value", 32'(want.rec.bval), 32'(rsp.byte_value));
            same("error_code", 32'(want.rec.code), 32'(rsp.error_code));
            same("last_result", 32'(want.last), 32'(rsp.last_result));
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: watchdog, no handshake for %0d cycles, %0d results still owed",
               $time, WATCHDOG_LIMIT, pending_results.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
src/atl_pkg.sv
src/atl_if.sv
src/atl_front.sv
src/atl_queue.sv
src/atl_back.sv
src/assembler_token_lexer.sv
tb/sv/tb.sv
